// ===== rtl/core/scfr_pkg.sv =====
// Shared types and constants of the second-chance frame replacer.
package scfr_pkg;

    // Default sizes of the frame table
    localparam int FRAMES_DEF    = 256;
    localparam int PID_BITS_DEF  = 16;
    localparam int PAGE_BITS_DEF = 20;

    // Port field widths
    localparam int OP_W   = 2;
    localparam int PID_W  = 16;
    localparam int PAGE_W = 20;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;

    // Frame count after reset
    localparam logic [CNT_W-1:0] FC_RESET = 9'd256;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_QUERY  = 2'd1,
        OP_SETREF = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EVAL  = 2'd2
    } t_state;

endpackage

// ===== rtl/core/scfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/second_chance_frame_replacer.sv =====
// Query, set referenced, free: the entry is read on start, evaluated in ST_EVAL, and the result strobed as busy falls.
// Allocate: the block stays in ST_EVAL while the hand passes k referenced frames, clearing their bits
// (k at most the clamped frame count); one frame-table read per cycle sets the walk speed.
// One item is taken per busy-low cycle; results are strobed for one cycle, no back-pressure.
// Reset (synchronous, active low) starts a clearing pass that zeroes every entry of the
// frame table with busy high; the hand returns to frame 0 and the frame count to 256.
module second_chance_frame_replacer #(
    parameter int FRAMES    = scfr_pkg::FRAMES_DEF,
    parameter int PID_BITS  = scfr_pkg::PID_BITS_DEF,
    parameter int PAGE_BITS = scfr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scfr_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [scfr_pkg::OP_W-1:0]     i_op,
    input  logic [scfr_pkg::PID_W-1:0]    i_pid,
    input  logic [scfr_pkg::PAGE_W-1:0]   i_page_no,
    input  logic [scfr_pkg::IDX_W-1:0]    i_frame_index,
    output logic                          o_done,
    output logic [scfr_pkg::IDX_W-1:0]    o_frame,
    output logic                          o_evicted,
    output logic [scfr_pkg::PID_W-1:0]    o_evicted_pid,
    output logic [scfr_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic                          o_mapped
);
    import scfr_pkg::*;

    localparam int AW     = $clog2(FRAMES);
    localparam int EW     = PID_BITS + PAGE_BITS + 2;
    localparam int NW     = ($clog2(FRAMES + 1) > CNT_W) ? $clog2(FRAMES + 1) : CNT_W;
    localparam int PG_LO  = 2;
    localparam int PID_LO = PAGE_BITS + 2;

    // Entry layout: {pid, page, mapped, referenced}
    localparam int B_REF = 0;
    localparam int B_MAP = 1;

    // Control registers
    t_state             r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_hand, n_hand;
    logic [CNT_W-1:0]   r_fc;
    logic               r_done, n_done;
    logic               r_fwd, n_fwd;

    // Payload registers
    t_op                r_op;
    logic [PID_BITS-1:0]  r_pid;
    logic [PAGE_BITS-1:0] r_page;
    logic [IDX_W-1:0]   r_idx;
    logic               r_idx_ok;
    logic [NW-1:0]      r_n;
    logic [EW-1:0]      r_fwd_data;
    logic [IDX_W-1:0]   r_frame, n_frame;
    logic               r_evicted, n_evicted;
    logic [PID_W-1:0]   r_ev_pid, n_ev_pid;
    logic [PAGE_W-1:0]  r_ev_page, n_ev_page;
    logic               r_mapped, n_mapped;

    // Memory port signals
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [EW-1:0]      ram_wdata, ram_rdata;

    logic               accept;
    logic [NW-1:0]      fc_ext, n_lim, addr_inc;
    logic [AW-1:0]      start_hand, nxt_addr;
    logic [EW-1:0]      ent;

    scfr_ram #(
        .WIDTH (EW),
        .DEPTH (FRAMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Clamp the frame count to 1..FRAMES
    assign fc_ext = NW'(r_fc);
    always_comb begin
        if (fc_ext == '0) begin
            n_lim = NW'(1);
        end else if (fc_ext > NW'(FRAMES)) begin
            n_lim = NW'(FRAMES);
        end else begin
            n_lim = fc_ext;
        end
    end

    // Wrap the hand if the count was lowered to or below it
    assign start_hand = (NW'(r_hand) >= n_lim) ? '0 : r_hand;

    // Step the walk address, wrapping at the frame count
    assign addr_inc = NW'(r_addr) + NW'(1);
    assign nxt_addr = (addr_inc >= r_n) ? '0 : AW'(addr_inc);

    // Take written data when the read hit the entry written alongside it
    assign ent = r_fwd ? r_fwd_data : ram_rdata;

    // Next state, memory accesses and result
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_hand    = r_hand;
        n_done    = 1'b0;
        n_frame   = r_frame;
        n_evicted = r_evicted;
        n_ev_pid  = r_ev_pid;
        n_ev_page = r_ev_page;
        n_mapped  = r_mapped;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_addr;

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == AW'(FRAMES - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end

            ST_IDLE: begin
                if (start) begin
                    ram_re = 1'b1;
                    if (t_op'(i_op) == OP_ALLOC) begin
                        ram_raddr = start_hand;
                    end else begin
                        ram_raddr = AW'(i_frame_index);
                    end
                    n_addr  = ram_raddr;
                    n_state = ST_EVAL;
                end
            end

            ST_EVAL: begin
                // Defaults for a finished item
                n_frame   = r_idx;
                n_evicted = 1'b0;
                n_ev_pid  = '0;
                n_ev_page = '0;
                n_mapped  = 1'b0;
                case (r_op)
                    OP_ALLOC: begin
                        ram_we = 1'b1;
                        if (ent[B_REF]) begin
                            // Second chance: clear the bit and move on
                            ram_wdata        = ent;
                            ram_wdata[B_REF] = 1'b0;
                            ram_re           = 1'b1;
                            ram_raddr        = nxt_addr;
                            n_addr           = nxt_addr;
                        end else begin
                            // Claim this frame
                            ram_wdata = {r_pid, r_page, 1'b1, 1'b0};
                            n_hand    = nxt_addr;
                            n_done    = 1'b1;
                            n_frame   = IDX_W'(r_addr);
                            n_mapped  = 1'b1;
                            n_evicted = ent[B_MAP];
                            if (ent[B_MAP]) begin
                                n_ev_pid  = PID_W'(ent[EW-1:PID_LO]);
                                n_ev_page = PAGE_W'(ent[PID_LO-1:PG_LO]);
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        n_mapped = r_idx_ok && ent[B_MAP];
                        n_done   = 1'b1;
                        n_state  = ST_IDLE;
                    end
                    OP_SETREF: begin
                        ram_we           = r_idx_ok;
                        ram_wdata        = ent;
                        ram_wdata[B_REF] = 1'b1;
                        n_done           = 1'b1;
                        n_state          = ST_IDLE;
                    end
                    OP_FREE: begin
                        ram_we  = r_idx_ok;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_fwd = ram_we && ram_re && (ram_waddr == ram_raddr);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_hand  <= '0;
            r_fc    <= FC_RESET;
            r_done  <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_hand  <= n_hand;
            r_done  <= n_done;
            r_fwd   <= n_fwd;
            if (i_cfg_we) begin
                r_fc <= i_cfg_wdata;
            end
        end
    end

    // Latch the item and hold the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_op);
            r_pid    <= PID_BITS'(i_pid);
            r_page   <= PAGE_BITS'(i_page_no);
            r_idx    <= i_frame_index;
            r_idx_ok <= (NW'(i_frame_index) < NW'(FRAMES));
            r_n      <= n_lim;
        end
        r_fwd_data <= ram_wdata;
        r_frame    <= n_frame;
        r_evicted  <= n_evicted;
        r_ev_pid   <= n_ev_pid;
        r_ev_page  <= n_ev_page;
        r_mapped   <= n_mapped;
    end

    assign o_done         = r_done;
    assign o_frame        = r_frame;
    assign o_evicted      = r_evicted;
    assign o_evicted_pid  = r_ev_pid;
    assign o_evicted_page = r_ev_page;
    assign o_mapped       = r_mapped;

endmodule

// ===== rtl/core/scfr_chk.sv =====
// Port-level checks of the second-chance frame replacer, bound to the top level.
module scfr_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [scfr_pkg::OP_W-1:0]     i_op,
    input  logic [scfr_pkg::IDX_W-1:0]    i_frame_index,
    input  logic                          o_done,
    input  logic [scfr_pkg::IDX_W-1:0]    o_frame,
    input  logic                          o_evicted,
    input  logic [scfr_pkg::PID_W-1:0]    o_evicted_pid,
    input  logic [scfr_pkg::PAGE_W-1:0]   o_evicted_page,
    input  logic                          o_mapped
);
    import scfr_pkg::*;

    // An accepted item makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // A result ends a busy spell
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a busy spell");

    // Indexed requests answer through ST_EVAL and the result register with their own frame
    a_index_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op != OP_ALLOC)) |=> ##1
        (o_done && (o_frame == $past(i_frame_index, 2))))
        else $error("indexed request answered late or with a wrong frame");

    // An eviction comes only with a mapped claim
    a_evict_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> o_mapped)
        else $error("eviction reported without a claimed frame");

    // No eviction, no evicted owner
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evicted) |-> ((o_evicted_pid == '0) && (o_evicted_page == '0)))
        else $error("evicted owner reported without an eviction");

endmodule

bind second_chance_frame_replacer scfr_chk u_scfr_chk (.*);
